@@ rtl/core/lva_pkg.sv @@
// Shared types, constants and voice-class helpers for the LRU voice allocator.
// No dependencies; used by lru_voice_allocator and its port checker.
package lva_pkg;

   localparam int NUM_VOICES = 18;
   localparam int STAMP_BITS = 32;
   localparam int VOICE_BITS = $clog2(NUM_VOICES);
   localparam int CLASS_BITS = 2;
   localparam int NUM_CLASSES = 3;
   localparam int PARTNER_OFS = 3;

   typedef logic [1:0]            mode_type;
   typedef logic [VOICE_BITS-1:0] voice_type;
   typedef logic [STAMP_BITS-1:0] stamp_type;
   typedef logic [CLASS_BITS-1:0] class_type;

   localparam mode_type MODE_OFF = 2'd0;
   localparam mode_type MODE_ON2 = 2'd1;
   localparam mode_type MODE_ON4 = 2'd2;
   localparam mode_type MODE_NA  = 2'd3;

   localparam logic CMD_ALLOC   = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   localparam class_type CLASS_FREE  = 2'd0;
   localparam class_type CLASS_CHEAP = 2'd1;
   localparam class_type CLASS_EXP   = 2'd2;

   typedef struct packed {
      mode_type  mode;
      stamp_type stamp;
   } entry_type;

   // voices 0-2 and 9-11 can lead a four-op pair
   function automatic logic is_leader(input voice_type v);
      return (v < voice_type'(3)) || (v > voice_type'(8) && v < voice_type'(12));
   endfunction

   // voices 3-5 and 12-14 serve as four-op partners
   function automatic logic is_partner(input voice_type v);
      return (v > voice_type'(2) && v < voice_type'(6)) ||
             (v > voice_type'(11) && v < voice_type'(15));
   endfunction

endpackage

@@ rtl/core/lru_voice_allocator.sv @@
// LRU voice allocator top level: voice table memory, scan sequencer, shared comparator.
// Depends on lva_pkg.
//
// Command channel: req_cmd/req_four_op/req_voice_index transfer on a clock edge with
//   start high and busy low. busy stays high through the result cycle and drops in
//   the cycle after it.
// Result channel: rsp_strobe is high for exactly one cycle with rsp_chosen_voice,
//   rsp_found and rsp_cost_class; the receiver cannot stall. One result per command.
// CSR channel: csr_voices_in_use transfers when csr_valid and csr_ready are high;
//   ready only while idle. Values above 18 scan all 18 voices.
// Datapath: one voice table memory with a registered read, one shared magnitude comparator.
// Allocate: each scanned voice is read and evaluated; unavailable voices are skipped,
//   and on a four-op request only leaders are scored, with their partner read too.
//   The best candidate is then picked, re-read and committed, its partner written
//   too where needed, or a miss is reported. Release: the voice is read and written
//   off and its four-op partner freed; an out-of-range voice gives a not-found result.
// Reset: synchronous; all voices read as off with stamp zero (per-entry valid
//   bits), use counter zero, voices_in_use 18.
module lru_voice_allocator (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_cmd,
   input  logic                   req_four_op,
   input  logic [4:0]             req_voice_index,
   output logic                   rsp_strobe,
   output logic [4:0]             rsp_chosen_voice,
   output logic                   rsp_found,
   output logic [1:0]             rsp_cost_class,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [4:0]             csr_voices_in_use
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_RD   = 4'd1;
   localparam logic [3:0] ST_EV   = 4'd2;
   localparam logic [3:0] ST_PRD  = 4'd3;
   localparam logic [3:0] ST_PEV  = 4'd4;
   localparam logic [3:0] ST_UPD  = 4'd5;
   localparam logic [3:0] ST_PICK = 4'd6;
   localparam logic [3:0] ST_CRD  = 4'd7;
   localparam logic [3:0] ST_CEV  = 4'd8;
   localparam logic [3:0] ST_W2   = 4'd9;
   localparam logic [3:0] ST_RRD  = 4'd10;
   localparam logic [3:0] ST_REV  = 4'd11;
   localparam logic [3:0] ST_DONE = 4'd12;

   localparam lva_pkg::voice_type LAST_VOICE = lva_pkg::voice_type'(lva_pkg::NUM_VOICES);
   localparam lva_pkg::voice_type PART_OFS   = lva_pkg::voice_type'(lva_pkg::PARTNER_OFS);

   // voice table
   lva_pkg::entry_type mem [0:lva_pkg::NUM_VOICES-1];
   logic [lva_pkg::NUM_VOICES-1:0] vld_ff, vld_in;
   lva_pkg::entry_type  rdata_ff;
   logic                rvld_ff;
   lva_pkg::voice_type  rd_addr;
   logic                mem_we;
   lva_pkg::voice_type  wr_addr;
   lva_pkg::mode_type   wr_mode;

   // control and datapath registers
   logic [3:0]          state_ff, state_in;
   logic [4:0]          viu_ff, viu_in;
   lva_pkg::stamp_type  cnt_ff, cnt_in;
   logic                four_ff, four_in;
   lva_pkg::voice_type  vidx_ff, vidx_in;
   lva_pkg::voice_type  lim_ff, lim_in;
   lva_pkg::voice_type  idx_ff, idx_in;
   lva_pkg::stamp_type  cur_t_ff, cur_t_in;
   lva_pkg::class_type  cur_c_ff, cur_c_in;
   lva_pkg::mode_type   cur_m_ff, cur_m_in;
   logic [lva_pkg::NUM_CLASSES-1:0] have_ff, have_in;
   lva_pkg::stamp_type  age_ff [0:lva_pkg::NUM_CLASSES-1];
   lva_pkg::stamp_type  age_in [0:lva_pkg::NUM_CLASSES-1];
   lva_pkg::voice_type  who_ff [0:lva_pkg::NUM_CLASSES-1];
   lva_pkg::voice_type  who_in [0:lva_pkg::NUM_CLASSES-1];
   lva_pkg::voice_type  sel_ff, sel_in;
   lva_pkg::class_type  cls_ff, cls_in;
   lva_pkg::voice_type  w2_addr_ff, w2_addr_in;
   lva_pkg::mode_type   w2_mode_ff, w2_mode_in;
   lva_pkg::voice_type  res_voice_ff, res_voice_in;
   logic                res_found_ff, res_found_in;
   lva_pkg::class_type  res_class_ff, res_class_in;

   // entry as seen by the sequencer; unwritten entries read as off, stamp zero
   lva_pkg::mode_type   rd_mode;
   lva_pkg::stamp_type  rd_stamp;
   assign rd_mode  = rvld_ff ? rdata_ff.mode  : lva_pkg::MODE_OFF;
   assign rd_stamp = rvld_ff ? rdata_ff.stamp : '0;

   // shared magnitude comparator
   lva_pkg::stamp_type  cmp_b;
   logic                cmp_lt;
   assign cmp_b  = (state_ff == ST_PEV) ? rd_stamp : age_ff[cur_c_ff];
   assign cmp_lt = cur_t_ff < cmp_b;

   lva_pkg::voice_type  idx_nx;
   assign idx_nx = idx_ff + lva_pkg::voice_type'(1);

   assign busy             = (state_ff != ST_IDLE);
   assign csr_ready        = (state_ff == ST_IDLE);
   assign rsp_strobe       = (state_ff == ST_DONE);
   assign rsp_chosen_voice = res_voice_ff;
   assign rsp_found        = res_found_ff;
   assign rsp_cost_class   = res_class_ff;

   always_comb begin
      logic ev_busy;
      logic ev_cls1;
      ev_busy = (rd_mode != lva_pkg::MODE_OFF);
      ev_cls1 = lva_pkg::is_leader(idx_ff) || lva_pkg::is_partner(idx_ff) || ev_busy;

      state_in     = state_ff;
      viu_in       = viu_ff;
      cnt_in       = cnt_ff;
      four_in      = four_ff;
      vidx_in      = vidx_ff;
      lim_in       = lim_ff;
      idx_in       = idx_ff;
      cur_t_in     = cur_t_ff;
      cur_c_in     = cur_c_ff;
      cur_m_in     = cur_m_ff;
      have_in      = have_ff;
      age_in       = age_ff;
      who_in       = who_ff;
      sel_in       = sel_ff;
      cls_in       = cls_ff;
      w2_addr_in   = w2_addr_ff;
      w2_mode_in   = w2_mode_ff;
      res_voice_in = res_voice_ff;
      res_found_in = res_found_ff;
      res_class_in = res_class_ff;
      vld_in       = vld_ff;
      rd_addr      = idx_ff;
      mem_we       = 1'b0;
      wr_addr      = sel_ff;
      wr_mode      = lva_pkg::MODE_OFF;

      if (csr_valid && csr_ready) begin
         viu_in = csr_voices_in_use;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               four_in      = req_four_op;
               vidx_in      = req_voice_index;
               lim_in       = (viu_ff > LAST_VOICE) ? LAST_VOICE : viu_ff;
               idx_in       = '0;
               have_in      = '0;
               res_voice_in = '0;
               res_found_in = 1'b0;
               res_class_in = lva_pkg::CLASS_FREE;
               if (req_cmd == lva_pkg::CMD_RELEASE) begin
                  state_in = (req_voice_index >= LAST_VOICE) ? ST_DONE : ST_RRD;
               end else begin
                  state_in = (viu_ff == '0) ? ST_PICK : ST_RD;
               end
            end
         end
         ST_RD: begin
            rd_addr  = idx_ff;
            state_in = ST_EV;
         end
         ST_EV: begin
            cur_t_in = rd_stamp;
            cur_m_in = rd_mode;
            if (rd_mode == lva_pkg::MODE_NA ||
                (four_ff && !lva_pkg::is_leader(idx_ff))) begin
               idx_in   = idx_nx;
               state_in = (idx_nx >= lim_ff) ? ST_PICK : ST_RD;
            end else if (four_ff) begin
               state_in = ST_PRD;
            end else begin
               cur_c_in = lva_pkg::class_type'({1'b0, ev_cls1}) +
                          lva_pkg::class_type'({1'b0, ev_busy});
               state_in = ST_UPD;
            end
         end
         ST_PRD: begin
            rd_addr  = idx_ff + PART_OFS;
            state_in = ST_PEV;
         end
         ST_PEV: begin
            // partner on two-op costs one more and its stamp may set the age
            cur_c_in = lva_pkg::class_type'({1'b0, cur_m_ff != lva_pkg::MODE_OFF}) +
                       lva_pkg::class_type'({1'b0, rd_mode == lva_pkg::MODE_ON2});
            if (rd_mode == lva_pkg::MODE_ON2 && cmp_lt) begin
               cur_t_in = rd_stamp;
            end
            state_in = ST_UPD;
         end
         ST_UPD: begin
            if (!have_ff[cur_c_ff] || cmp_lt) begin
               have_in[cur_c_ff] = 1'b1;
               age_in[cur_c_ff]  = cur_t_ff;
               who_in[cur_c_ff]  = idx_ff;
            end
            idx_in   = idx_nx;
            state_in = (idx_nx >= lim_ff) ? ST_PICK : ST_RD;
         end
         ST_PICK: begin
            state_in = ST_CRD;
            priority if (have_ff[0]) begin
               sel_in = who_ff[0];
               cls_in = lva_pkg::CLASS_FREE;
            end else if (have_ff[1]) begin
               sel_in = who_ff[1];
               cls_in = lva_pkg::CLASS_CHEAP;
            end else if (have_ff[2]) begin
               sel_in = who_ff[2];
               cls_in = lva_pkg::CLASS_EXP;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_CRD: begin
            rd_addr  = sel_ff;
            state_in = ST_CEV;
         end
         ST_CEV: begin
            mem_we       = 1'b1;
            wr_addr      = sel_ff;
            wr_mode      = four_ff ? lva_pkg::MODE_ON4 : lva_pkg::MODE_ON2;
            vld_in[sel_ff] = 1'b1;
            cnt_in       = cnt_ff + lva_pkg::stamp_type'(1);
            res_voice_in = sel_ff;
            res_found_in = 1'b1;
            res_class_in = cls_ff;
            w2_addr_in   = sel_ff + PART_OFS;
            w2_mode_in   = four_ff ? lva_pkg::MODE_NA : lva_pkg::MODE_OFF;
            if (four_ff || (rd_mode == lva_pkg::MODE_ON4 &&
                            (sel_ff + PART_OFS) < LAST_VOICE)) begin
               state_in = ST_W2;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_RRD: begin
            rd_addr  = vidx_ff;
            state_in = ST_REV;
         end
         ST_REV: begin
            mem_we       = 1'b1;
            wr_addr      = vidx_ff;
            wr_mode      = lva_pkg::MODE_OFF;
            vld_in[vidx_ff] = 1'b1;
            cnt_in       = cnt_ff + lva_pkg::stamp_type'(1);
            res_voice_in = vidx_ff;
            res_found_in = 1'b1;
            w2_addr_in   = vidx_ff + PART_OFS;
            w2_mode_in   = lva_pkg::MODE_OFF;
            if (rd_mode == lva_pkg::MODE_ON4 && (vidx_ff + PART_OFS) < LAST_VOICE) begin
               state_in = ST_W2;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_W2: begin
            mem_we   = 1'b1;
            wr_addr  = w2_addr_ff;
            wr_mode  = w2_mode_ff;
            vld_in[w2_addr_ff] = 1'b1;
            cnt_in   = cnt_ff + lva_pkg::stamp_type'(1);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= '{mode: wr_mode, stamp: cnt_ff};
      end
      rdata_ff <= mem[rd_addr];
      rvld_ff  <= vld_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         viu_ff   <= 5'(lva_pkg::NUM_VOICES);
         cnt_ff   <= '0;
         vld_ff   <= '0;
         have_ff  <= '0;
      end else begin
         state_ff <= state_in;
         viu_ff   <= viu_in;
         cnt_ff   <= cnt_in;
         vld_ff   <= vld_in;
         have_ff  <= have_in;
      end
   end

   always_ff @(posedge clock) begin
      four_ff      <= four_in;
      vidx_ff      <= vidx_in;
      lim_ff       <= lim_in;
      idx_ff       <= idx_in;
      cur_t_ff     <= cur_t_in;
      cur_c_ff     <= cur_c_in;
      cur_m_ff     <= cur_m_in;
      age_ff       <= age_in;
      who_ff       <= who_in;
      sel_ff       <= sel_in;
      cls_ff       <= cls_in;
      w2_addr_ff   <= w2_addr_in;
      w2_mode_ff   <= w2_mode_in;
      res_voice_ff <= res_voice_in;
      res_found_ff <= res_found_in;
      res_class_ff <= res_class_in;
   end

endmodule

@@ rtl/core/lva_checker.sv @@
// Port-level checker for lru_voice_allocator, attached by bind.
// Depends on lva_pkg.
module lva_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_strobe,
   input logic [4:0] rsp_chosen_voice,
   input logic       rsp_found,
   input logic [1:0] rsp_cost_class
);

   // an accepted command keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("command transfer did not raise busy");

   // a result only shows while a command is in flight
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe while idle");

   // one result per command: the strobe is never held high
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   // a miss reports all zero
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_found |-> rsp_chosen_voice == 5'd0 && rsp_cost_class == 2'd0)
      else $error("not-found result carries data");

   // a hit names a real voice and a defined class
   a_hit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_found |->
         rsp_chosen_voice < 5'(lva_pkg::NUM_VOICES) &&
         rsp_cost_class < 2'(lva_pkg::NUM_CLASSES))
      else $error("found result out of range");

endmodule

bind lru_voice_allocator lva_checker u_lva_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_chosen_voice (rsp_chosen_voice),
   .rsp_found        (rsp_found),
   .rsp_cost_class   (rsp_cost_class)
);

@@ test/lva_port_checker.sv @@
// Port checker for lru_voice_allocator: watches the command, result and CSR channels,
// keeps its own voice table to predict each result, and counts mismatches.
// Depends on lva_pkg.
module lva_port_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       busy,
   input  logic       req_cmd,
   input  logic       req_four_op,
   input  logic [4:0] req_voice_index,
   input  logic       rsp_strobe,
   input  logic [4:0] rsp_chosen_voice,
   input  logic       rsp_found,
   input  logic [1:0] rsp_cost_class,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [4:0] csr_voices_in_use,
   output int         fail_count,
   output int         pending,
   output int         free_hits,
   output int         cheap_hits,
   output int         costly_hits,
   output int         miss_hits,
   output int         release_hits
);

   // leader voices 0-2, 9-11; partner voices 3-5, 12-14
   localparam logic [lva_pkg::NUM_VOICES-1:0] LEAD_MASK = 18'b000000111000000111;
   localparam logic [lva_pkg::NUM_VOICES-1:0] PART_MASK = 18'b000111000000111000;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      lva_pkg::voice_type voice;
      logic               found;
      lva_pkg::class_type cls;
   } outcome_type;

   lva_pkg::mode_type  mode_tbl [lva_pkg::NUM_VOICES];
   lva_pkg::stamp_type stamp_tbl [lva_pkg::NUM_VOICES];
   lva_pkg::stamp_type stamp_next;
   logic [4:0]         scan_limit;
   outcome_type        outcome_q [$];

   function automatic lva_pkg::stamp_type take_stamp();
      take_stamp = stamp_next;
      stamp_next = stamp_next + 1'b1;
   endfunction

   // frees the partner of a four-op leader, if it has one
   function automatic void free_partner(input int v);
      if (mode_tbl[v] == lva_pkg::MODE_ON4 &&
          v + lva_pkg::PARTNER_OFS < lva_pkg::NUM_VOICES) begin
         stamp_tbl[v + lva_pkg::PARTNER_OFS] = take_stamp();
         mode_tbl[v + lva_pkg::PARTNER_OFS] = lva_pkg::MODE_OFF;
      end
   endfunction

   function automatic outcome_type run_command(input logic cmd, input logic four,
                                               input logic [4:0] idx);
      outcome_type        res;
      int                 lim;
      int                 best;
      int                 c;
      int                 v;
      int                 p;
      logic               have [lva_pkg::NUM_CLASSES];
      lva_pkg::stamp_type age [lva_pkg::NUM_CLASSES];
      int                 who [lva_pkg::NUM_CLASSES];
      lva_pkg::stamp_type t;
      res = '0;
      if (cmd == lva_pkg::CMD_RELEASE) begin
         if (idx >= lva_pkg::NUM_VOICES)
            return res;
         v = idx;
         stamp_tbl[v] = take_stamp();
         free_partner(v);
         mode_tbl[v] = lva_pkg::MODE_OFF;
         res.voice = lva_pkg::voice_type'(idx);
         res.found = 1'b1;
         release_hits++;
         return res;
      end
      for (c = 0; c < lva_pkg::NUM_CLASSES; c++) begin
         have[c] = 1'b0;
         age[c] = '0;
         who[c] = 0;
      end
      lim = (scan_limit > lva_pkg::NUM_VOICES) ? lva_pkg::NUM_VOICES : int'(scan_limit);
      for (int i = 0; i < lim; i++) begin
         if (mode_tbl[i] == lva_pkg::MODE_NA)
            continue;
         t = stamp_tbl[i];
         c = 0;
         if (four) begin
            p = i + lva_pkg::PARTNER_OFS;
            if (!LEAD_MASK[i] || p >= lva_pkg::NUM_VOICES)
               continue;
            if (mode_tbl[i] != lva_pkg::MODE_OFF)
               c++;
            // a busy two-op partner makes the pair costlier and its age counts
            if (mode_tbl[p] == lva_pkg::MODE_ON2) begin
               c++;
               if (stamp_tbl[p] > t)
                  t = stamp_tbl[p];
            end
         end else begin
            if (LEAD_MASK[i] || PART_MASK[i] || mode_tbl[i] != lva_pkg::MODE_OFF)
               c++;
            if (mode_tbl[i] != lva_pkg::MODE_OFF)
               c++;
         end
         if (!have[c] || t < age[c]) begin
            have[c] = 1'b1;
            age[c] = t;
            who[c] = i;
         end
      end
      best = -1;
      for (c = lva_pkg::NUM_CLASSES - 1; c >= 0; c--)
         if (have[c])
            best = c;
      if (best < 0) begin
         miss_hits++;
         return res;
      end
      v = who[best];
      stamp_tbl[v] = take_stamp();
      if (four) begin
         mode_tbl[v] = lva_pkg::MODE_ON4;
         stamp_tbl[v + lva_pkg::PARTNER_OFS] = take_stamp();
         mode_tbl[v + lva_pkg::PARTNER_OFS] = lva_pkg::MODE_NA;
      end else begin
         free_partner(v);
         mode_tbl[v] = lva_pkg::MODE_ON2;
      end
      res.voice = lva_pkg::voice_type'(v);
      res.found = 1'b1;
      res.cls = lva_pkg::class_type'(best);
      case (res.cls)
         lva_pkg::CLASS_FREE:  free_hits++;
         lva_pkg::CLASS_CHEAP: cheap_hits++;
         default:              costly_hits++;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         for (int i = 0; i < lva_pkg::NUM_VOICES; i++) begin
            mode_tbl[i] = lva_pkg::MODE_OFF;
            stamp_tbl[i] = '0;
         end
         stamp_next = '0;
         scan_limit = 5'(lva_pkg::NUM_VOICES);
         outcome_q.delete();
         fail_count = 0;
         free_hits = 0;
         cheap_hits = 0;
         costly_hits = 0;
         miss_hits = 0;
         release_hits = 0;
      end else begin
         if (csr_valid && csr_ready)
            scan_limit = csr_voices_in_use;
         if (start && !busy)
            outcome_q.push_back(run_command(req_cmd, req_four_op, req_voice_index));
         if (rsp_strobe) begin
            if (outcome_q.size() == 0) begin
               if (fail_count < REPORT_LIMIT)
                  $display("ERROR: result voice=%0d found=%0d class=%0d with none pending",
                           rsp_chosen_voice, rsp_found, rsp_cost_class);
               fail_count++;
            end else begin
               want = outcome_q.pop_front();
               if (rsp_chosen_voice !== want.voice || rsp_found !== want.found ||
                   rsp_cost_class !== want.cls) begin
                  if (fail_count < REPORT_LIMIT)
                     $display("ERROR: expected voice=%0d found=%0d class=%0d, got %0d/%0d/%0d",
                              want.voice, want.found, want.cls,
                              rsp_chosen_voice, rsp_found, rsp_cost_class);
                  fail_count++;
               end
            end
         end
      end
      pending = outcome_q.size();
   end

endmodule

@@ test/lru_voice_allocator_tb.sv @@
// Testbench top for lru_voice_allocator: drives commands and scan-count writes,
// runs a cycle watchdog and reports the verdict. Depends on lva_pkg and lva_port_checker.
module lru_voice_allocator_tb;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 8;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   logic       req_cmd;
   logic       req_four_op;
   logic [4:0] req_voice_index;
   logic       rsp_strobe;
   logic [4:0] rsp_chosen_voice;
   logic       rsp_found;
   logic [1:0] rsp_cost_class;
   logic       csr_valid;
   logic       csr_ready;
   logic [4:0] csr_voices_in_use;

   int fail_count, pending;
   int free_hits, cheap_hits, costly_hits, miss_hits, release_hits;
   int commands_sent;
   int quiet_cycles;
   int unsigned mid_scan;

   lru_voice_allocator DUT (.*);

   lva_port_checker CHK (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: watchdog expired, %0d results outstanding", pending);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_item(input logic cmd, input logic four, input logic [4:0] idx);
      start <= 1'b1;
      req_cmd <= cmd;
      req_four_op <= four;
      req_voice_index <= idx;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      commands_sent++;
      @(negedge clock);
   endtask

   task automatic idle_for(input int n);
      start <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (pending != 0)
         @(negedge clock);
   endtask

   task automatic write_scan_count(input logic [4:0] value);
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid <= 1'b1;
      csr_voices_in_use <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_item();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         send_item(lva_pkg::CMD_ALLOC, $urandom_range(0, 99) < 40,
                   5'($urandom_range(0, 31)));
      else if (pick < 90)
         send_item(lva_pkg::CMD_RELEASE, 1'($urandom_range(0, 1)),
                   5'($urandom_range(0, 17)));
      else
         send_item(lva_pkg::CMD_RELEASE, 1'($urandom_range(0, 1)),
                   5'($urandom_range(18, 31)));
   endtask

   task automatic run_phase(input logic [4:0] scan, input int count, input bit gaps);
      bit calm;
      write_scan_count(scan);
      calm = 1'b0;
      for (int n = 0; n < count; n++) begin
         // every 50 items, pick at random between idle-heavy and back-to-back stretches
         if (n % 50 == 0)
            calm = ($urandom_range(0, 2) == 0);
         if (gaps && $urandom_range(0, 63) == 0)
            drain();
         random_item();
         if (gaps && !calm && $urandom_range(0, 3) == 0)
            idle_for($urandom_range(1, 12));
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_cmd = lva_pkg::CMD_ALLOC;
      req_four_op = 1'b0;
      req_voice_index = '0;
      csr_valid = 1'b0;
      csr_voices_in_use = '0;
      commands_sent = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: range edges, free voices, full leader set, partner handling
      send_item(lva_pkg::CMD_RELEASE, 1'b1, 5'd31);
      send_item(lva_pkg::CMD_RELEASE, 1'b0, 5'd18);
      send_item(lva_pkg::CMD_RELEASE, 1'b0, 5'd17);
      send_item(lva_pkg::CMD_RELEASE, 1'b1, 5'd0);
      send_item(lva_pkg::CMD_ALLOC, 1'b0, 5'd31);
      repeat (6) send_item(lva_pkg::CMD_ALLOC, 1'b1, 5'd0);
      send_item(lva_pkg::CMD_ALLOC, 1'b1, 5'd17);
      send_item(lva_pkg::CMD_RELEASE, 1'b0, 5'd3);
      send_item(lva_pkg::CMD_ALLOC, 1'b0, 5'd0);
      send_item(lva_pkg::CMD_ALLOC, 1'b1, 5'd0);
      send_item(lva_pkg::CMD_RELEASE, 1'b0, 5'd1);
      send_item(lva_pkg::CMD_RELEASE, 1'b0, 5'd9);
      send_item(lva_pkg::CMD_RELEASE, 1'b0, 5'd15);
      repeat (4) send_item(lva_pkg::CMD_ALLOC, 1'b0, 5'd0);
      send_item(lva_pkg::CMD_ALLOC, 1'b1, 5'd0);
      drain();

      mid_scan = $urandom_range(2, 17);
      run_phase(5'd31, 300, 1'b1);
      run_phase(5'd0, 60, 1'b1);
      run_phase(5'd1, 200, 1'b1);
      run_phase(5'd7, 300, 1'b1);
      run_phase(5'd12, 300, 1'b1);
      run_phase(5'(mid_scan), 300, 1'b1);
      run_phase(5'd18, 400, 1'b0);

      drain();
      repeat (100) @(negedge clock);
      $display("Summary: %0d commands over scan counts 18, 31, 0, 1, 7, 12, %0d and 18",
               commands_sent, mid_scan);
      $display("Summary: allocations free/cheap/expensive %0d/%0d/%0d, not found %0d, releases %0d",
               free_hits, cheap_hits, costly_hits, miss_hits, release_hits);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/lva_pkg.sv
rtl/core/lru_voice_allocator.sv
rtl/core/lva_checker.sv
test/lva_port_checker.sv
test/lru_voice_allocator_tb.sv
